// File: rtl/assert_macros.svh
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// clocked assertion on the default clock and reset names
`define ASSERT_DEF(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// File: rtl/pedd_pkg.sv
// types, constants and commands for the palette error diffusion dither
`default_nettype none
package pedd_pkg;

  localparam int DEF_MAX_WIDTH     = 2048;
  localparam int DEF_PALETTE_DEPTH = 256;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int PSIZE_W    = 9;
  localparam int LWIDTH_W   = 12;
  localparam int COLOR_W    = 8;
  localparam int COLUMN_W   = 11;
  localparam int CHAN_W     = 8;

  localparam logic [PSIZE_W-1:0]  PSIZE_RESET  = 9'd2;
  localparam logic [LWIDTH_W-1:0] LWIDTH_RESET = 12'd640;

  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'd1;

  typedef enum logic [1:0] {
    KIND_PALETTE = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_FRAME   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_CORR,
    ST_SEARCH,
    ST_DRAIN,
    ST_ERR,
    ST_SHARE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic pal_load;
    logic frame_clr;
    logic rd_cur;
    logic corr;
    logic search_issue;
    logic err_calc;
    logic share_calc;
    logic rmw_rd;
    logic rmw_wr;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic pipe_idle;
    logic tgt_last;
    logic out_free;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// File: rtl/pedd_ctrl.sv
// sequencing state machine for one item at a time
`default_nettype none
module pedd_ctrl
  import pedd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] kind_i,
  input  ctrl_stat_t      stat_i,
  output logic            in_stall_o,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_e'(kind_i))
            KIND_PALETTE: cmd_o.pal_load = 1'b1;
            KIND_PIXEL: begin
              cmd_o.capture = 1'b1;
              state_d       = ST_RD_CUR;
            end
            KIND_FRAME: cmd_o.frame_clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RD_CUR: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_CORR;
      end
      ST_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd_o.search_issue = 1'b1;
        if (stat_i.issue_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat_i.pipe_idle) state_d = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.err_calc = 1'b1;
        state_d        = ST_SHARE;
      end
      ST_SHARE: begin
        cmd_o.share_calc = 1'b1;
        state_d          = ST_RMW_RD;
      end
      ST_RMW_RD: begin
        cmd_o.rmw_rd = 1'b1;
        state_d      = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        cmd_o.rmw_wr = 1'b1;
        state_d      = stat_i.tgt_last ? ST_OUT : ST_RMW_RD;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/pedd_dpath.sv
// datapath: palette, error rows, nearest color search and diffusion
`default_nettype none
module pedd_dpath
  import pedd_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  ctrl_cmd_t                  cmd_i,
  output ctrl_stat_t                 stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [CHAN_W-1:0]     entry_index_i,
  input  wire logic [CHAN_W-1:0]     red_i,
  input  wire logic [CHAN_W-1:0]     green_i,
  input  wire logic [CHAN_W-1:0]     blue_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [COLOR_W-1:0]         color_index_o,
  output logic [COLUMN_W-1:0]        column_o,
  output logic                       row_end_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CB = $clog2(MAX_WIDTH + 2);
  localparam int FW = $clog2(MAX_WIDTH + 3);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam int NW = $clog2(PALETTE_DEPTH + 1);

  // truncating divide by 256 of a signed 16-bit error cell
  function automatic logic signed [7:0] div256(input logic [15:0] v);
    logic signed [16:0] t;
    t = $signed({v[15], v}) + (v[15] ? 17'sd255 : 17'sd0);
    return t[15:8];
  endfunction

  // truncating divide by 16, low 16 bits kept
  function automatic logic [15:0] div16(input logic signed [21:0] v);
    logic signed [21:0] t;
    t = v + (v[21] ? 22'sd15 : 22'sd0);
    return t[19:4];
  endfunction

  // squared distance of one channel
  function automatic logic [17:0] sqr(input logic [7:0] p, input logic signed [9:0] c);
    logic signed [10:0] df;
    logic signed [21:0] pr;
    df = $signed({3'b000, p}) - $signed({c[9], c});
    pr = df * df;
    return pr[17:0];
  endfunction

  // configuration registers
  logic [PSIZE_W-1:0]  psize_q;
  logic [LWIDTH_W-1:0] lwidth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q  <= PSIZE_RESET;
      lwidth_q <= LWIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PALETTE_SIZE: psize_q  <= cfg_data_i[PSIZE_W-1:0];
        REG_LINE_WIDTH:   lwidth_q <= cfg_data_i[LWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped palette size and line width
  logic [NW-1:0] n_sat;
  logic [WW-1:0] w_sat;

  always_comb begin
    if (psize_q == '0) begin
      n_sat = NW'(1);
    end else if (psize_q > PSIZE_W'(PALETTE_DEPTH)) begin
      n_sat = NW'(PALETTE_DEPTH);
    end else begin
      n_sat = NW'(psize_q);
    end
    if (lwidth_q == '0) begin
      w_sat = WW'(1);
    end else if ({1'b0, lwidth_q} > 13'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(lwidth_q);
    end
  end

  // palette memory
  logic [23:0]   pal_mem [PALETTE_DEPTH];
  logic [23:0]   pal_rd_q;
  logic [PW-1:0] idx_q;
  logic          pal_ok;

  assign pal_ok = ({1'b0, entry_index_i} < 9'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.pal_load && pal_ok) begin
      pal_mem[PW'(entry_index_i)] <= {red_i, green_i, blue_i};
    end
    if (cmd_i.search_issue) begin
      pal_rd_q <= pal_mem[idx_q];
    end
  end

  // pixel capture
  logic [CHAN_W-1:0] px_q [3];
  logic [XW-1:0]     x_q;
  logic [XW-1:0]     col_q;
  logic              bank_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q[0] <= red_i;
      px_q[1] <= green_i;
      px_q[2] <= blue_i;
      x_q     <= col_q;
    end
  end

  // error row addressing: target 0 right, 1 down-left, 2 down, 3 down-right
  logic [1:0]    tgt_q;
  logic          tgt_bank;
  logic [CB-1:0] tgt_cell;

  always_comb begin
    unique case (tgt_q)
      2'd0: begin
        tgt_bank = bank_q;
        tgt_cell = CB'(x_q) + CB'(2);
      end
      2'd1: begin
        tgt_bank = ~bank_q;
        tgt_cell = CB'(x_q);
      end
      2'd2: begin
        tgt_bank = ~bank_q;
        tgt_cell = CB'(x_q) + CB'(1);
      end
      default: begin
        tgt_bank = ~bank_q;
        tgt_cell = CB'(x_q) + CB'(2);
      end
    endcase
  end

  // error row memory, cells past the fill count read as zero
  logic [47:0]   err_mem [2**(CB+1)];
  logic [47:0]   rdata_q;
  logic          rvalid_q;
  logic [FW-1:0] fill_q [2];
  logic          rd_en;
  logic          rd_bank;
  logic [CB-1:0] rd_cell;
  logic [47:0]   old_cell;
  logic [47:0]   wdata;
  logic [15:0]   share_q [4][3];

  assign rd_en    = cmd_i.rd_cur | cmd_i.rmw_rd;
  assign rd_bank  = cmd_i.rd_cur ? bank_q : tgt_bank;
  assign rd_cell  = cmd_i.rd_cur ? (CB'(x_q) + CB'(1)) : tgt_cell;
  assign old_cell = rvalid_q ? rdata_q : '0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wdata[47-16*k -: 16] = old_cell[47-16*k -: 16] + share_q[tgt_q][k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q  <= err_mem[{rd_bank, rd_cell}];
      rvalid_q <= (FW'(rd_cell) < fill_q[rd_bank]);
    end
    if (cmd_i.rmw_wr) begin
      err_mem[{tgt_bank, tgt_cell}] <= wdata;
    end
  end

  // row end check
  logic row_last;
  assign row_last = ((WW+1)'(x_q) + (WW+1)'(1)) >= (WW+1)'(w_sat);

  // fill counts, row position, target counter and search index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q[0] <= '0;
      fill_q[1] <= '0;
      bank_q    <= 1'b0;
      col_q     <= '0;
      tgt_q     <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.frame_clr) begin
        fill_q[0] <= '0;
        fill_q[1] <= '0;
        bank_q    <= 1'b0;
        col_q     <= '0;
      end else if (cmd_i.capture && col_q == '0) begin
        fill_q[~bank_q] <= '0;
      end else if (cmd_i.rmw_wr && FW'(tgt_cell) >= fill_q[tgt_bank]) begin
        fill_q[tgt_bank] <= FW'(tgt_cell) + FW'(1);
      end
      if (cmd_i.capture) begin
        tgt_q <= '0;
        idx_q <= '0;
      end else begin
        if (cmd_i.rmw_wr) tgt_q <= tgt_q + 2'd1;
        if (cmd_i.search_issue) idx_q <= idx_q + PW'(1);
      end
      if (cmd_i.finish) begin
        if (row_last) begin
          col_q  <= '0;
          bank_q <= ~bank_q;
        end else begin
          col_q <= x_q + XW'(1);
        end
      end
    end
  end

  // corrected color
  logic signed [9:0] corr_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.corr) begin
      for (int k = 0; k < 3; k++) begin
        corr_q[k] <= $signed({2'b00, px_q[k]})
                   + 10'(div256(rvalid_q ? rdata_q[47-16*k -: 16] : 16'd0));
      end
    end
  end

  // search pipeline: palette read, squares, compare
  logic          v1_q, v2_q;
  logic [PW-1:0] i1_q, i2_q;
  logic [23:0]   c2_q;
  logic [17:0]   sq_q [3];
  logic [19:0]   dsum;
  logic [19:0]   best_d_q;
  logic [PW-1:0] best_i_q;
  logic [23:0]   best_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.search_issue;
      v2_q <= v1_q;
    end
  end

  assign dsum = 20'(sq_q[0]) + 20'(sq_q[1]) + 20'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    i1_q <= idx_q;
    i2_q <= i1_q;
    c2_q <= pal_rd_q;
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= sqr(pal_rd_q[23-8*k -: 8], corr_q[k]);
    end
    if (v2_q && (i2_q == '0 || dsum < best_d_q)) begin
      best_d_q <= dsum;
      best_i_q <= i2_q;
      best_c_q <= c2_q;
    end
  end

  // error and its four shares
  logic signed [18:0] e_q [3];
  logic signed [10:0] delta [3];
  logic signed [21:0] e_x [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      delta[k] = $signed({corr_q[k][9], corr_q[k]})
               - $signed({3'b000, best_c_q[23-8*k -: 8]});
      e_x[k]   = {{3{e_q[k][18]}}, e_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_calc) begin
      for (int k = 0; k < 3; k++) begin
        e_q[k] <= $signed({delta[k], 8'b0}) - $signed({{8{delta[k][10]}}, delta[k]});
      end
    end
    if (cmd_i.share_calc) begin
      for (int k = 0; k < 3; k++) begin
        share_q[0][k] <= div16($signed({e_q[k], 3'b000}) - e_x[k]);
        share_q[1][k] <= div16($signed({{2{e_q[k][18]}}, e_q[k], 1'b0}) + e_x[k]);
        share_q[2][k] <= div16($signed({e_q[k][18], e_q[k], 2'b00}) + e_x[k]);
        share_q[3][k] <= div16(e_x[k]);
      end
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      color_index_o <= COLOR_W'(best_i_q);
      column_o      <= COLUMN_W'(x_q);
      row_end_o     <= row_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // status to the controller
  assign stat_o.issue_last = (NW'(idx_q) == n_sat - NW'(1));
  assign stat_o.pipe_idle  = ~v1_q & ~v2_q;
  assign stat_o.tgt_last   = (tgt_q == 2'd3);
  assign stat_o.out_free   = ~out_valid_q | ~out_stall_i;

endmodule
`default_nettype wire

// File: rtl/palette_error_diffusion_dither.sv
// top level of the palette error diffusion dither
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | kind, entry_index, red, green, blue
//  out     | output    | out_valid_o / out_stall_i | color_index, column, row_end
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index, cfg_data
//
// a pixel stalls the input while it is worked on, n the clamped palette size: n search
// reads at one palette entry per cycle, a pipeline drain, the read-modify-write of four
// error cells and five control steps; its result is registered once the output is free,
// and the next item can be taken in the cycle in which that result shows.
// palette loads and frame starts do not stall the input.
// reset needs no clearing pass: per-row fill counts make unwritten cells read as zero.
// a stalled output holds one result while the next item is already being worked on.
`default_nettype none
module palette_error_diffusion_dither
  import pedd_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [CHAN_W-1:0]     entry_index_i,
  input  wire logic [CHAN_W-1:0]     red_i,
  input  wire logic [CHAN_W-1:0]     green_i,
  input  wire logic [CHAN_W-1:0]     blue_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [COLOR_W-1:0]         color_index_o,
  output logic [COLUMN_W-1:0]        column_o,
  output logic                       row_end_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // controller
  pedd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // datapath
  pedd_dpath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .color_index_o (color_index_o),
    .column_o      (column_o),
    .row_end_o     (row_end_o)
  );

endmodule
`default_nettype wire

// File: rtl/pedd_checker.sv
// port-level checks for the dither, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module pedd_checker
  import pedd_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic [1:0]            kind_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [COLOR_W-1:0]    color_index_o,
  input wire logic [COLUMN_W-1:0]   column_o,
  input wire logic                  row_end_o
);

  logic pix_acc;
  logic other_acc;
  logic out_wait;

  assign pix_acc   = in_valid_i & ~in_stall_o & (kind_i == KIND_PIXEL);
  assign other_acc = in_valid_i & ~in_stall_o & (kind_i != KIND_PIXEL);
  assign out_wait  = out_valid_o & out_stall_i;

  // a pixel item blocks the input while it is searched
  `ASSERT_DEF(a_pixel_busy, pix_acc |=> in_stall_o)

  // a load, frame start or unused kind never makes a result
  `ASSERT_DEF(a_no_spurious, (other_acc && !out_valid_o) |=> !out_valid_o)

  // a new result only shows after a busy cycle
  `ASSERT_DEF(a_result_after_work, $rose(out_valid_o) |-> $past(in_stall_o))

  // a held result keeps its payload
  `ASSERT_DEF(a_hold, out_wait |=> (out_valid_o && $stable({color_index_o, column_o, row_end_o})))

endmodule

bind palette_error_diffusion_dither pedd_checker u_pedd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .kind_i        (kind_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .color_index_o (color_index_o),
  .column_o      (column_o),
  .row_end_o     (row_end_o)
);
`default_nettype wire

// File: verif/palette_error_diffusion_dither_checker.sv
// checker for the palette error diffusion dither: predicts palette indexes and compares
module palette_error_diffusion_dither_checker
  import pedd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            kind_i,
  input  logic [CHAN_W-1:0]     entry_index_i,
  input  logic [CHAN_W-1:0]     red_i,
  input  logic [CHAN_W-1:0]     green_i,
  input  logic [CHAN_W-1:0]     blue_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [COLOR_W-1:0]    color_index_i,
  input  logic [COLUMN_W-1:0]   column_i,
  input  logic                  row_end_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW  = DEF_MAX_WIDTH;
  localparam int DEPTH = DEF_PALETTE_DEPTH;

  typedef struct {
    logic [COLOR_W-1:0]  color_index;
    logic [COLUMN_W-1:0] column;
    logic                row_end;
  } pixel_out_t;

  // model copy of the block state
  logic [23:0]       palette_mem [DEPTH];
  logic [15:0]       diff_err [2][MAXW+2][3];
  bit                cur_bank;
  int                col_count;
  logic [PSIZE_W-1:0]  psize;
  logic [LWIDTH_W-1:0] lwidth;
  pixel_out_t        expected_pixels [$];

  assign pending_o = expected_pixels.size();

  initial begin
    fail_count_o = 0;
    cur_bank = 0;
    col_count = 0;
    psize = PSIZE_RESET;
    lwidth = LWIDTH_RESET;
    foreach (palette_mem[i]) palette_mem[i] = '0;
    foreach (diff_err[b, c, k]) diff_err[b][c][k] = '0;
  end

  function automatic int comp(logic [23:0] rgb, int k);
    return int'(rgb[16-8*k +: 8]);
  endfunction

  // dither one pixel and queue the chosen index
  function automatic void dither_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, n, x, nb, best, bestd, d, t;
    int px[3], corr[3], e[3];
    pixel_out_t res;
    bit last;
    px[0] = r; px[1] = g; px[2] = b;
    w = lwidth; if (w < 1) w = 1; if (w > MAXW) w = MAXW;
    n = psize;  if (n < 1) n = 1; if (n > DEPTH) n = DEPTH;
    x = col_count; if (x >= MAXW) x = MAXW - 1;
    nb = cur_bank ^ 1'b1;
    // a new row clears the row below
    if (x == 0)
      for (int c = 0; c < MAXW + 2; c++)
        for (int k = 0; k < 3; k++) diff_err[nb][c][k] = '0;
    for (int k = 0; k < 3; k++)
      corr[k] = px[k] + int'($signed(diff_err[cur_bank][x+1][k])) / 256;
    best = 0;
    bestd = 0;
    for (int i = 0; i < n; i++) begin
      d = 0;
      for (int k = 0; k < 3; k++) begin
        t = comp(palette_mem[i], k) - corr[k];
        d += t * t;
      end
      if (i == 0 || d < bestd) begin
        bestd = d;
        best = i;
      end
    end
    // spread the error to the four neighbours
    for (int k = 0; k < 3; k++) begin
      e[k] = 255 * (corr[k] - comp(palette_mem[best], k));
      diff_err[cur_bank][x+2][k] += 16'(e[k] * 7 / 16);
      diff_err[nb][x][k]         += 16'(e[k] * 3 / 16);
      diff_err[nb][x+1][k]       += 16'(e[k] * 5 / 16);
      diff_err[nb][x+2][k]       += 16'(e[k] / 16);
    end
    last = (x + 1 >= w);
    res.color_index = best[7:0];
    res.column = x[10:0];
    res.row_end = last;
    expected_pixels.push_back(res);
    if (last) begin
      col_count = 0;
      cur_bank = nb;
    end else begin
      col_count = x + 1;
    end
  endfunction

  // register writes
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_i) begin
      if (cfg_index_i == REG_PALETTE_SIZE) psize = cfg_data_i[PSIZE_W-1:0];
      else if (cfg_index_i == REG_LINE_WIDTH) lwidth = cfg_data_i[LWIDTH_W-1:0];
    end
  end

  // accepted input items
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_i) begin
      if (kind_i == KIND_PALETTE) begin
        palette_mem[entry_index_i] = {red_i, green_i, blue_i};
      end else if (kind_i == KIND_FRAME) begin
        foreach (diff_err[b, c, k]) diff_err[b][c][k] = '0;
        cur_bank = 0;
        col_count = 0;
      end else if (kind_i == KIND_PIXEL) begin
        dither_pixel(red_i, green_i, blue_i);
      end
    end
  end

  // accepted results
  always @(posedge clk_i) begin
    pixel_out_t exp_px;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: color_index %0d column %0d", color_index_i, column_i);
        fail_count_o++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (color_index_i !== exp_px.color_index) begin
          $error("color_index expected %0d actual %0d", exp_px.color_index, color_index_i);
          fail_count_o++;
        end
        if (column_i !== exp_px.column) begin
          $error("column expected %0d actual %0d", exp_px.column, column_i);
          fail_count_o++;
        end
        if (row_end_i !== exp_px.row_end) begin
          $error("row_end expected %0d actual %0d", exp_px.row_end, row_end_i);
          fail_count_o++;
        end
      end
    end
  end
endmodule

// File: verif/palette_error_diffusion_dither_tb.sv
// testbench top for the palette error diffusion dither: stimulus and verdict
module palette_error_diffusion_dither_tb;
  import pedd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE = 300;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [1:0] kind_i = KIND_PIXEL;
  logic [CHAN_W-1:0] entry_index_i = '0, red_i = '0, green_i = '0, blue_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [COLOR_W-1:0] color_index_o;
  logic [COLUMN_W-1:0] column_o;
  logic row_end_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_PALETTE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int pending, fail_count, cycles;
  int idle_pct = 6;

  always #5 clk_i = ~clk_i;

  palette_error_diffusion_dither u_dut (.*);

  palette_error_diffusion_dither_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .entry_index_i,
    .red_i, .green_i, .blue_i, .out_valid_i(out_valid_o), .out_stall_i,
    .color_index_i(color_index_o),
    .column_i(column_o), .row_end_i(row_end_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .pending_o(pending), .fail_count_o(fail_count)
  );

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // random output stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  // send one item, with an occasional idle gap before it
  task automatic send_item(logic [1:0] kind, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= kind;
    entry_index_i <= idx;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_pixel();
    send_item(KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  initial begin
    int sel, psz, lw;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: palette extremes, every kind, color extremes
    send_item(KIND_PALETTE, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(KIND_PALETTE, 8'd1, 8'hff, 8'hff, 8'hff);
    send_item(KIND_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(KIND_PIXEL, 8'd0, 8'hff, 8'hff, 8'hff);
    send_item(KIND_PIXEL, 8'd0, 8'h80, 8'h7f, 8'h80);
    send_item(KIND_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(KIND_PIXEL, 8'hff, 8'h7f, 8'h80, 8'h7f);
    send_item(KIND_FRAME, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(KIND_PIXEL, 8'd0, 8'hff, 8'h00, 8'hff);
    // duplicate entries: the first one wins on ties
    send_item(KIND_PALETTE, 8'd1, 8'h00, 8'h00, 8'h00);
    send_item(KIND_PIXEL, 8'd0, 8'h10, 8'h10, 8'h10);
    drain();

    // line width zero, palette size zero
    write_reg(REG_PALETTE_SIZE, 12'd0);
    write_reg(REG_LINE_WIDTH, 12'd0);
    repeat (3) send_pixel();
    drain();

    // fill the whole palette
    for (int i = 0; i < 256; i++) begin
      send_item(KIND_PALETTE, i[7:0], 8'($urandom), 8'($urandom), 8'($urandom));
    end
    send_item(KIND_PALETTE, 8'd255, 8'hff, 8'h00, 8'hff);

    // phases of random items under varied settings
    for (int ph = 0; ph < 14; ph++) begin
      drain();
      case (ph)
        0:       begin psz = 256; lw = 2048; end
        1:       begin psz = 511; lw = 4095; end
        2:       begin psz = 1;   lw = 1;    end
        3:       begin psz = 256; lw = 3;    end
        default: begin psz = $urandom_range(2, 16); lw = $urandom_range(1, 12); end
      endcase
      write_reg(REG_PALETTE_SIZE, psz[11:0]);
      write_reg(REG_LINE_WIDTH, lw[11:0]);
      idle_pct = (ph == 6) ? 0 : 6;
      for (int n = 0; n < ((ph < 2) ? 10 : 22); n++) begin
        sel = $urandom_range(99);
        if (sel < 85) send_pixel();
        else if (sel < 93) begin
          send_item(KIND_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (sel < 97) begin
          send_item(KIND_FRAME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          send_item(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/pedd_pkg.sv
rtl/pedd_ctrl.sv
rtl/pedd_dpath.sv
rtl/palette_error_diffusion_dither.sv
rtl/pedd_checker.sv
verif/palette_error_diffusion_dither_checker.sv
verif/palette_error_diffusion_dither_tb.sv
